[hw/rtl/kss_pkg.sv]
// kss_pkg: shared sizes, control state encoding and the command/status
// structs that join the k-sorted stream sorter controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package kss_pkg;

  // Heap storage and element size
  localparam int HEAP_DEPTH = 16;
  localparam int DATA_WIDTH = 32;

  // Window register width (greatest displacement)
  localparam int K_W = 4;

  // Heap index, entry count and child index widths
  localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CHW   = IDX_W + 2;

  // Width used to compare the entry count against the capacity
  localparam int CAP_W = (CNT_W > K_W + 1) ? CNT_W : K_W + 1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RT_RD,
    ST_RT_CMP,
    ST_SU_RD,
    ST_SU_CMP,
    ST_SD_RD,
    ST_SD_CMP,
    ST_DR_RD,
    ST_DR_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // latch input word, insert slot if heap not full
    logic rd_root;      // read root on port a
    logic rd_parent;    // read parent of pos on port a
    logic rd_children;  // read both children of pos on ports a and b
    logic rd_drain;     // read root on port a and last entry on port b
    logic wr_x;         // write held value at pos
    logic wr_parent;    // move parent down into pos, pos moves up
    logic wr_child;     // move smaller child up into pos, pos moves down
    logic emit_root;    // send root out, hole at root
    logic emit_x;       // send held value straight out
    logic emit_drain;   // send root out, shrink heap, last entry refills root
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;         // entry count at or above capacity
    logic last;         // held word closes the sequence
    logic pos_zero;     // hole is at the root
    logic has_child;    // hole has at least one child in the heap
    logic x_lt_a;       // held value below port a word
    logic root_lt_x;    // port a word (root) below held value
    logic child_lt_x;   // smaller child below held value
    logic cnt_one;      // one entry left
    logic out_free;     // output register can take a word
  } sts_t;

endpackage

[hw/rtl/kss_ctrl.sv]
// kss_ctrl: state machine that sequences insert, replace-root, sift and
// drain steps of the sorter. Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kss_pkg::sts_t sts,
  output kss_pkg::cmd_t cmd
);

  kss_pkg::state_t state;
  kss_pkg::state_t state_next;
  kss_pkg::state_t finish_state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // After a placement or a direct emit: drain if the word closed the sequence
  assign finish_state = sts.last ? kss_pkg::ST_DR_RD : kss_pkg::ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.full ? kss_pkg::ST_RT_RD : kss_pkg::ST_SU_RD;
        end
      end
      kss_pkg::ST_RT_RD: begin
        cmd.rd_root = 1'b1;
        state_next  = kss_pkg::ST_RT_CMP;
      end
      kss_pkg::ST_RT_CMP: begin
        if (sts.out_free) begin
          if (sts.root_lt_x) begin
            cmd.emit_root = 1'b1;
            state_next    = kss_pkg::ST_SD_RD;
          end else begin
            cmd.emit_x = 1'b1;
            state_next = finish_state;
          end
        end
      end
      kss_pkg::ST_SU_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_x   = 1'b1;
          state_next = finish_state;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = kss_pkg::ST_SU_CMP;
        end
      end
      kss_pkg::ST_SU_CMP: begin
        if (sts.x_lt_a) begin
          cmd.wr_parent = 1'b1;
          state_next    = kss_pkg::ST_SU_RD;
        end else begin
          cmd.wr_x   = 1'b1;
          state_next = finish_state;
        end
      end
      kss_pkg::ST_SD_RD: begin
        if (!sts.has_child) begin
          cmd.wr_x   = 1'b1;
          state_next = finish_state;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = kss_pkg::ST_SD_CMP;
        end
      end
      kss_pkg::ST_SD_CMP: begin
        if (sts.child_lt_x) begin
          cmd.wr_child = 1'b1;
          state_next   = kss_pkg::ST_SD_RD;
        end else begin
          cmd.wr_x   = 1'b1;
          state_next = finish_state;
        end
      end
      kss_pkg::ST_DR_RD: begin
        cmd.rd_drain = 1'b1;
        state_next   = kss_pkg::ST_DR_EMIT;
      end
      kss_pkg::ST_DR_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_drain = 1'b1;
          state_next     = sts.cnt_one ? kss_pkg::ST_IDLE : kss_pkg::ST_SD_RD;
        end
      end
      default: begin
        state_next = kss_pkg::ST_IDLE;
      end
    endcase
  end

  // A word is taken only from idle, and work always follows it
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != kss_pkg::ST_IDLE)
    else $error("accepted word did not start work");

  // Drain read is always followed by the drain emit step
  a_drain_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_drain |=> state == kss_pkg::ST_DR_EMIT)
    else $error("drain read not followed by emit");

  // Input is ready only while idle
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == kss_pkg::ST_IDLE)
    else $error("input ready outside idle");

endmodule

[hw/rtl/kss_datapath.sv]
// kss_datapath: heap memory (one write, two registered read ports), hole
// position, entry count, window register, compare logic and output register.
// Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kss_pkg::cmd_t                        cmd,
  output kss_pkg::sts_t                        sts,
  input  logic signed [kss_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                                 in_last,
  input  logic                                 cfg_wr_en,
  input  logic        [kss_pkg::K_W-1:0]        cfg_wr_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [kss_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                 out_last
);

  // Heap memory
  logic signed [kss_pkg::DATA_WIDTH-1:0] mem [kss_pkg::HEAP_DEPTH];
  logic signed [kss_pkg::DATA_WIDTH-1:0] rd_a;
  logic signed [kss_pkg::DATA_WIDTH-1:0] rd_b;

  // Control registers
  logic [kss_pkg::K_W-1:0]   window_k;
  logic [kss_pkg::CNT_W-1:0] count;
  logic [kss_pkg::IDX_W-1:0] pos;
  logic signed [kss_pkg::DATA_WIDTH-1:0] x;
  logic                      last;

  // Derived values
  logic [kss_pkg::CAP_W-1:0] cap_raw;
  logic [kss_pkg::CAP_W-1:0] cap;
  logic [kss_pkg::CNT_W-1:0] cnt_dec;
  logic [kss_pkg::CHW-1:0]   child_l;
  logic [kss_pkg::CHW-1:0]   child_r;
  logic [kss_pkg::IDX_W-1:0] parent;
  logic                      has_right;
  logic                      right_lt;
  logic signed [kss_pkg::DATA_WIDTH-1:0] child_val;
  logic [kss_pkg::IDX_W-1:0] child_idx;
  logic [kss_pkg::IDX_W-1:0] addr_a;
  logic [kss_pkg::IDX_W-1:0] addr_b;
  logic                      rd_en;
  logic                      wr_en;
  logic signed [kss_pkg::DATA_WIDTH-1:0] wr_data;
  logic                      emit;

  // Capacity is window plus one, saturated at the heap depth
  assign cap_raw = kss_pkg::CAP_W'(window_k) + kss_pkg::CAP_W'(1);
  assign cap     = (cap_raw > kss_pkg::CAP_W'(kss_pkg::HEAP_DEPTH)) ?
                   kss_pkg::CAP_W'(kss_pkg::HEAP_DEPTH) : cap_raw;

  // Heap index arithmetic
  assign cnt_dec = count - kss_pkg::CNT_W'(1);
  assign child_l = kss_pkg::CHW'({pos, 1'b1});
  assign child_r = kss_pkg::CHW'({pos, 1'b0}) + kss_pkg::CHW'(2);
  assign parent  = (pos - kss_pkg::IDX_W'(1)) >> 1;
  assign has_right = child_r < kss_pkg::CHW'(count);

  // Smaller child; ties go to the left one
  assign right_lt  = has_right && (rd_b < rd_a);
  assign child_val = right_lt ? rd_b : rd_a;
  assign child_idx = right_lt ? child_r[kss_pkg::IDX_W-1:0] : child_l[kss_pkg::IDX_W-1:0];

  // Status to controller
  assign sts.full       = kss_pkg::CAP_W'(count) >= cap;
  assign sts.last       = last;
  assign sts.pos_zero   = pos == '0;
  assign sts.has_child  = child_l < kss_pkg::CHW'(count);
  assign sts.x_lt_a     = x < rd_a;
  assign sts.root_lt_x  = rd_a < x;
  assign sts.child_lt_x = child_val < x;
  assign sts.cnt_one    = count == kss_pkg::CNT_W'(1);
  assign sts.out_free   = !out_valid || out_ready;

  // Read address selection
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (cmd.rd_parent) begin
      addr_a = parent;
    end else if (cmd.rd_children) begin
      addr_a = child_l[kss_pkg::IDX_W-1:0];
      addr_b = child_r[kss_pkg::IDX_W-1:0];
    end else if (cmd.rd_drain) begin
      addr_b = cnt_dec[kss_pkg::IDX_W-1:0];
    end
  end

  assign rd_en = cmd.rd_root || cmd.rd_parent || cmd.rd_children || cmd.rd_drain;

  // Write data: held value, parent moving down or child moving up
  assign wr_en   = cmd.wr_x || cmd.wr_parent || cmd.wr_child;
  assign wr_data = cmd.wr_x ? x : (cmd.wr_parent ? rd_a : child_val);

  // Heap memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_k <= '0;
    end else if (cfg_wr_en) begin
      window_k <= cfg_wr_data;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && !sts.full) begin
      count <= count + kss_pkg::CNT_W'(1);
    end else if (cmd.emit_drain) begin
      count <= cnt_dec;
    end
  end

  // Held value, last flag and hole position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x    <= in_value;
      last <= in_last;
      pos  <= count[kss_pkg::IDX_W-1:0];
    end else if (cmd.emit_root) begin
      pos <= '0;
    end else if (cmd.emit_drain) begin
      x   <= rd_b;
      pos <= '0;
    end else if (cmd.wr_parent) begin
      pos <= parent;
    end else if (cmd.wr_child) begin
      pos <= child_idx;
    end
  end

  // Output register
  assign emit = cmd.emit_root || cmd.emit_x || cmd.emit_drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= cmd.emit_x ? x : rd_a;
      out_last  <= cmd.emit_drain && sts.cnt_one;
    end
  end

  // Entry count never passes the heap depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= kss_pkg::CNT_W'(kss_pkg::HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  // A word is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("output word overwritten");

  // The word marked last leaves the heap empty
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_drain && sts.cnt_one) |=> count == '0)
    else $error("heap not empty after final word");

endmodule

[hw/rtl/k_sorted_stream_sorter_top.sv]
// A word goes into a non-full heap and sifts up; on a full heap it either leaves
// straight away or replaces the root, which goes out, and sifts down. A last word
// then drains the heap, root first. Words are taken one at a time: a new word is
// accepted only once the last one is placed or the drain is done, and output
// stalls hold the sorter; each compare step follows a registered heap memory read.
// Reset (rst, synchronous, active high) empties the heap and clears window_k.
// Top level of the k-sorted stream sorter; depends on kss_pkg, kss_ctrl,
// kss_datapath.
`timescale 1ns / 1ps

module k_sorted_stream_sorter_top (
  input  logic                             clk,
  input  logic                             rst,
  // Window register write
  input  logic                             cfg_wr_en,
  input  logic [kss_pkg::K_W-1:0]          cfg_wr_data,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kss_pkg::DATA_WIDTH-1:0]   s_tdata,   // [31:0] in_value
  input  logic                             s_tlast,   // in_last
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kss_pkg::DATA_WIDTH-1:0]   m_tdata,   // [31:0] out_value
  output logic                             m_tlast    // out_last
);

  kss_pkg::cmd_t cmd;
  kss_pkg::sts_t sts;
  logic signed [kss_pkg::DATA_WIDTH-1:0] out_value;

  // Sequencer
  kss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Heap and output datapath
  kss_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    ($signed(s_tdata)),
    .in_last     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_value   (out_value),
    .out_last    (m_tlast)
  );

  assign m_tdata = out_value;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for k_sorted_stream_sorter_top: random and directed runs of signed words,
// checked against a heap-based sorter model kept in the bench. Depends on kss_pkg and the RTL.

module tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic signed [kss_pkg::DATA_WIDTH-1:0] value;
    logic                                  last;
  } word_t;

  typedef enum int {RUN_KSORTED, RUN_NOISE, RUN_DUPS} run_kind_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [kss_pkg::K_W-1:0]        cfg_wr_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [kss_pkg::DATA_WIDTH-1:0] s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [kss_pkg::DATA_WIDTH-1:0] m_tdata;
  logic                           m_tlast;

  // Sorter model state: heap contents, entry count, window setting
  logic signed [kss_pkg::DATA_WIDTH-1:0] heap_vals [0:kss_pkg::HEAP_DEPTH-1];
  int heap_cnt = 0;
  int win_k = 0;

  word_t feed_q [$];     // words waiting to go into the block
  word_t sorted_q [$];   // words the block still owes us
  int feed_left = 0;     // queued words not yet accepted
  int bad_words = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic in_taken = 1'b0;

  k_sorted_stream_sorter_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Heap moves, same tie rules as the block: swap only on strictly less
  function automatic void heap_sift_up(input int pos);
    logic signed [kss_pkg::DATA_WIDTH-1:0] t;
    int par;
    bit done;
    done = 1'b0;
    while (!done && pos > 0) begin
      par = (pos - 1) / 2;
      if (heap_vals[pos] < heap_vals[par]) begin
        t = heap_vals[pos];
        heap_vals[pos] = heap_vals[par];
        heap_vals[par] = t;
        pos = par;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  function automatic void heap_sift_down(input int pos);
    logic signed [kss_pkg::DATA_WIDTH-1:0] t;
    int c;
    bit done;
    done = 1'b0;
    while (!done) begin
      c = 2 * pos + 1;
      if (c >= heap_cnt) begin
        done = 1'b1;
      end else begin
        if (c + 1 < heap_cnt && heap_vals[c + 1] < heap_vals[c]) c = c + 1;
        if (heap_vals[c] < heap_vals[pos]) begin
          t = heap_vals[pos];
          heap_vals[pos] = heap_vals[c];
          heap_vals[c] = t;
          pos = c;
        end else begin
          done = 1'b1;
        end
      end
    end
  endfunction

  // Sorted words caused by one accepted input word
  function automatic void predict_sorted(input logic signed [kss_pkg::DATA_WIDTH-1:0] v,
                                         input logic lst);
    word_t res [0:kss_pkg::HEAP_DEPTH];
    int n;
    int cap;
    int k;
    n = 0;
    cap = win_k + 1;
    if (cap > kss_pkg::HEAP_DEPTH) cap = kss_pkg::HEAP_DEPTH;
    if (heap_cnt < cap) begin
      heap_vals[heap_cnt] = v;
      heap_cnt++;
      heap_sift_up(heap_cnt - 1);
    end else if (heap_vals[0] < v) begin
      res[n].value = heap_vals[0];
      res[n].last = 1'b0;
      n++;
      heap_vals[0] = v;
      heap_sift_down(0);
    end else begin
      res[n].value = v;
      res[n].last = 1'b0;
      n++;
    end
    // drain on end of sequence
    if (lst) begin
      while (heap_cnt > 0) begin
        res[n].value = heap_vals[0];
        res[n].last = 1'b0;
        n++;
        heap_cnt--;
        heap_vals[0] = heap_vals[heap_cnt];
        heap_sift_down(0);
      end
      if (n > 0) res[n - 1].last = 1'b1;
    end
    for (k = 0; k < n; k++) sorted_q.push_back(res[k]);
  endfunction

  task automatic flag_word(input string what, input word_t want, input word_t got);
    bad_words++;
    if (bad_words <= 10)
      $display("%0t %s: expected %0d last %0b, got %0d last %0b", $realtime, what,
               want.value, want.last, got.value, got.last);
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin : driver
    word_t nxt;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (feed_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.value;
          s_tlast <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check outgoing words, then predict for the incoming one
  always @(posedge clk) begin : monitor
    word_t got;
    word_t want;
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.value = m_tdata;
        got.last = m_tlast;
        if (sorted_q.size() == 0) begin
          want = '0;
          flag_word("unexpected word", want, got);
        end else begin
          want = sorted_q.pop_front();
          if (got.value !== want.value || got.last !== want.last)
            flag_word("word mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_sorted(s_tdata, s_tlast);
        feed_left--;
      end
    end
  end

  task automatic queue_word(input logic signed [kss_pkg::DATA_WIDTH-1:0] v,
                            input logic lst);
    word_t w;
    w.value = v;
    w.last = lst;
    feed_q.push_back(w);
    feed_left++;
  endtask

  // Hold off until every word is in and out, then let pending inserts settle
  task automatic wait_drained();
    while (feed_left != 0 || sorted_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input int k);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k[kss_pkg::K_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_k = k;
  endtask

  // One run of words; the k-sorted kind shuffles blocks of window+1 sorted values
  task automatic gen_run(input run_kind_t kind, input int len, input bit close);
    longint vals [0:63];
    longint acc;
    longint t;
    int i;
    int j;
    int b;
    int blk;
    int hi;
    case (kind)
      RUN_KSORTED: begin
        if ($urandom_range(3) == 0) acc = -64'sd2147483648;
        else acc = longint'($signed($urandom));
        for (i = 0; i < len; i++) begin
          if ($urandom_range(3) != 0)
            acc = acc + $urandom_range(1, 1 << $urandom_range(0, 24));
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          vals[i] = acc;
        end
        blk = win_k + 1;
        for (b = 0; b < len; b += blk) begin
          hi = (b + blk < len) ? b + blk : len;
          for (i = hi - 1; i > b; i--) begin
            j = b + $urandom_range(0, i - b);
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
          end
        end
      end
      RUN_NOISE: begin
        for (i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0: vals[i] = -64'sd2147483648;
            1: vals[i] = 64'sd2147483647;
            default: vals[i] = longint'($signed($urandom));
          endcase
        end
      end
      default: begin
        for (i = 0; i < len; i++) vals[i] = longint'($urandom_range(0, 3)) - 2;
      end
    endcase
    for (i = 0; i < len; i++)
      queue_word(vals[i][kss_pkg::DATA_WIDTH-1:0], close && (i == len - 1));
  endtask

  initial begin : stimulus
    int win_plan [0:8];
    int p;
    int n;
    int len;
    run_kind_t kind;
    bit close;
    win_plan = '{15, 0, 7, 2, 15, 1, 10, 4, 0};
    tx_idle_pct = 37;
    rx_idle_pct = 78;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Window 0: equal to root, below root, above root, extremes, last on full heap
    set_window(0);
    queue_word(32'sd5, 1'b0);
    queue_word(32'sd3, 1'b0);
    queue_word(32'sd5, 1'b0);
    queue_word(32'sd7, 1'b0);
    queue_word(32'sh8000_0000, 1'b1);
    queue_word(32'sh7fff_ffff, 1'b1);

    // Window 3: a k-sorted run, then a last word while the heap is not full
    set_window(3);
    queue_word(32'sd3, 1'b0);
    queue_word(32'sd1, 1'b0);
    queue_word(32'sd2, 1'b0);
    queue_word(32'sd6, 1'b0);
    queue_word(32'sd4, 1'b0);
    queue_word(32'sd5, 1'b1);
    queue_word(32'sd10, 1'b0);
    queue_word(32'sd9, 1'b0);
    queue_word(32'sd11, 1'b1);

    // Window shrinks from 5 to 1 with six entries held
    set_window(5);
    queue_word(32'sd60, 1'b0);
    queue_word(32'sd10, 1'b0);
    queue_word(32'sd50, 1'b0);
    queue_word(32'sd20, 1'b0);
    queue_word(32'sd40, 1'b0);
    queue_word(32'sd30, 1'b0);
    set_window(1);
    queue_word(32'sd35, 1'b0);
    queue_word(32'sd5, 1'b0);
    queue_word(32'sd70, 1'b1);

    // Random phases; a run left open spans the next window change
    for (p = 0; p < 9; p++) begin
      set_window(win_plan[p]);
      if (p == 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 37;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      n = 0;
      while (n < 42) begin
        case ($urandom_range(9))
          7: kind = RUN_NOISE;
          8: kind = RUN_DUPS;
          default: kind = RUN_KSORTED;
        endcase
        case (kind)
          RUN_KSORTED: len = $urandom_range(1, 3 * (win_k + 1) + 2);
          RUN_NOISE: len = $urandom_range(1, 20);
          default: len = $urandom_range(1, 24);
        endcase
        close = ($urandom_range(7) != 0);
        gen_run(kind, len, close);
        n += len;
      end
    end
    // close whatever is still held
    queue_word($signed($urandom), 1'b1);

    wait_drained();
    if (bad_words == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/kss_pkg.sv
hw/rtl/kss_ctrl.sv
hw/rtl/kss_datapath.sv
hw/rtl/k_sorted_stream_sorter_top.sv
tb/tb.sv
